@@ src/piu_pkg.sv @@
// Shared types, codes and helpers of the priority interrupt unit.
// No dependencies; used by piu_ctrl, piu_datapath and the top level.
package piu_pkg;

    // Operation codes carried on the input stream's tuser
    typedef enum logic [3:0] {
        OP_BOUNDARY   = 4'd0,
        OP_DEV_START  = 4'd1,
        OP_DEV_DONE   = 4'd2,
        OP_DEV_CLEAR  = 4'd3,
        OP_SKP_INTON  = 4'd4,
        OP_SKP_INTOFF = 4'd5,
        OP_SKP_PWRF   = 4'd6,
        OP_SKP_NOPWRF = 4'd7,
        OP_INTEN      = 4'd8,
        OP_INTDS      = 4'd9,
        OP_IORST      = 4'd10,
        OP_MSKO       = 4'd11,
        OP_INTA       = 4'd12,
        OP_READS      = 4'd13,
        OP_HALT       = 4'd14,
        OP_UNUSED     = 4'd15
    } op_t;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EXEC  = 5'b10000
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture the input word
        logic scan_start;  // reset scan counter and best candidate
        logic scan_step;   // issue one table read for the scan
        logic scan_addr;   // table read address comes from the scan counter
        logic exec;        // apply the operation and load the result word
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_inta;     // held operation is interrupt acknowledge
        logic scan_last;   // scan counter is at the last device
        logic out_free;    // result register can take a word this cycle
    } status_t;

    localparam int          LEVEL_W    = 4;
    localparam int          WORD_W     = 16;
    localparam int          DEV_W      = 6;
    localparam logic [4:0]  LEVEL_NONE = 5'd16;
    localparam logic [15:0] LEVEL_TOP  = 16'h8000;

    // Level 0 is bit 15 of the mask and pending words
    function automatic logic [WORD_W-1:0] level_bit(input logic [LEVEL_W-1:0] lvl);
        level_bit = LEVEL_TOP >> lvl;
    endfunction

endpackage

@@ src/piu_ctrl.sv @@
// Sequencing state machine of the priority interrupt unit.
// Depends on piu_pkg; drives piu_datapath through cmd_t, reads status_t.
module piu_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  piu_pkg::status_t  status,
    output piu_pkg::cmd_t     cmd
);

    piu_pkg::state_t state_reg;
    piu_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= piu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == piu_pkg::ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            piu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = piu_pkg::ST_FETCH;
                end
            end
            piu_pkg::ST_FETCH:
            begin
                if (status.is_inta)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = piu_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = piu_pkg::ST_EXEC;
                end
            end
            piu_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.scan_addr = 1'b1;
                if (status.scan_last)
                begin
                    state_next = piu_pkg::ST_DRAIN;
                end
            end
            piu_pkg::ST_DRAIN:
            begin
                state_next = piu_pkg::ST_EXEC;
            end
            piu_pkg::ST_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = piu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = piu_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/piu_datapath.sv @@
// Datapath of the priority interrupt unit: CPU interrupt state, device
// flags, device level memory, acknowledge scan and result register.
// Depends on piu_pkg; commanded by piu_ctrl.
module piu_datapath
#(
    parameter int NUM_DEVICES = 63
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  piu_pkg::cmd_t                 cmd,
    output piu_pkg::status_t              status,
    input  logic [3:0]                    in_op,
    input  logic [piu_pkg::DEV_W-1:0]     in_device,
    input  logic [piu_pkg::LEVEL_W-1:0]   in_level,
    input  logic [piu_pkg::WORD_W-1:0]    in_wdata,
    input  logic                          cfg_we,
    input  logic [piu_pkg::WORD_W-1:0]    cfg_wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_skip,
    output logic [piu_pkg::WORD_W-1:0]    out_rdata,
    output logic                          out_take,
    output logic                          out_halt,
    output logic                          out_done
);

    localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_DEVICES - 1);

    // Held input word
    piu_pkg::op_t                 op_reg;
    logic [piu_pkg::DEV_W-1:0]    dev_reg;
    logic [piu_pkg::LEVEL_W-1:0]  lvl_reg;
    logic [piu_pkg::WORD_W-1:0]   wdata_reg;

    // CPU interrupt state
    logic                         inton_reg, inton_next;
    logic                         enpend_reg, enpend_next;
    logic [piu_pkg::WORD_W-1:0]   mask_reg, mask_next;
    logic [piu_pkg::WORD_W-1:0]   plev_reg, plev_next;
    logic [piu_pkg::WORD_W-1:0]   switches_reg;

    // Per-device flags
    logic [NUM_DEVICES-1:0]       pend_reg, pend_next;
    logic [NUM_DEVICES-1:0]       busy_reg, busy_next;
    logic [NUM_DEVICES-1:0]       fin_reg, fin_next;
    logic [NUM_DEVICES-1:0]       lvalid_reg, lvalid_next;

    // Device level memory
    logic [piu_pkg::LEVEL_W-1:0]  level_mem [NUM_DEVICES];
    logic [piu_pkg::LEVEL_W-1:0]  lvl_rd_reg;
    logic [IDX_W-1:0]             rd_addr;
    logic                         lvl_we;

    // Scan state
    logic [IDX_W-1:0]             cnt_reg;
    logic [IDX_W-1:0]             cmp_idx_reg;
    logic                         cmp_valid_reg;
    logic [4:0]                   best_reg;
    logic [IDX_W-1:0]             best_dev_reg;
    logic [piu_pkg::LEVEL_W-1:0]  cmp_level;
    logic                         cmp_hit;

    // Result register
    logic                         out_valid_reg;
    logic                         skip_reg, skip_next;
    logic [piu_pkg::WORD_W-1:0]   rdata_reg, rdata_next;
    logic                         take_reg, take_next;
    logic                         halt_reg, halt_next;
    logic                         done_reg, done_next;

    logic [IDX_W-1:0]             dev_idx;
    logic                         dev_ok;
    logic [piu_pkg::LEVEL_W-1:0]  dev_level;

    assign dev_idx   = dev_reg[IDX_W-1:0];
    assign dev_ok    = ({1'b0, dev_reg} < 7'(NUM_DEVICES));
    assign dev_level = lvalid_reg[dev_idx] ? lvl_rd_reg : '0;

    assign status.is_inta   = (op_reg == piu_pkg::OP_INTA);
    assign status.scan_last = (cnt_reg == IDX_LAST);
    assign status.out_free  = !out_valid_reg || out_ready;

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= piu_pkg::op_t'(in_op);
            dev_reg   <= in_device;
            lvl_reg   <= in_level;
            wdata_reg <= in_wdata;
        end
    end

    // Level memory: one write port, one registered read port
    assign rd_addr = cmd.scan_addr ? cnt_reg : dev_idx;
    assign lvl_we  = cmd.exec && dev_ok && (op_reg == piu_pkg::OP_DEV_START);

    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            level_mem[dev_idx] <= lvl_reg;
        end
        lvl_rd_reg <= level_mem[rd_addr];
    end

    // Acknowledge scan: compare one device per cycle against the best so far
    assign cmp_level = lvalid_reg[cmp_idx_reg] ? lvl_rd_reg : '0;
    assign cmp_hit   = cmp_valid_reg && pend_reg[cmp_idx_reg]
                       && (|(piu_pkg::level_bit(cmp_level) & ~mask_reg))
                       && ({1'b0, cmp_level} < best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            cnt_reg      <= '0;
            best_reg     <= piu_pkg::LEVEL_NONE;
            best_dev_reg <= '0;
        end
        else
        begin
            if (cmd.scan_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmp_hit)
            begin
                best_reg     <= {1'b0, cmp_level};
                best_dev_reg <= cmp_idx_reg;
            end
        end
        cmp_idx_reg <= cnt_reg;
    end

    // Operation execute: next state and result word
    always_comb
    begin
        inton_next  = inton_reg;
        enpend_next = enpend_reg;
        mask_next   = mask_reg;
        plev_next   = plev_reg;
        pend_next   = pend_reg;
        busy_next   = busy_reg;
        fin_next    = fin_reg;
        lvalid_next = lvalid_reg;
        skip_next   = 1'b0;
        rdata_next  = '0;
        take_next   = 1'b0;
        halt_next   = 1'b0;
        case (op_reg)
            piu_pkg::OP_BOUNDARY:
            begin
                if (inton_reg && (|(plev_reg & ~mask_reg)))
                begin
                    take_next  = 1'b1;
                    inton_next = 1'b0;
                end
                if (enpend_reg)
                begin
                    inton_next  = 1'b1;
                    enpend_next = 1'b0;
                end
            end
            piu_pkg::OP_DEV_START:
            begin
                if (dev_ok)
                begin
                    busy_next[dev_idx]   = 1'b1;
                    lvalid_next[dev_idx] = 1'b1;
                end
            end
            piu_pkg::OP_DEV_DONE:
            begin
                if (dev_ok)
                begin
                    pend_next[dev_idx] = 1'b1;
                    if (busy_reg[dev_idx])
                    begin
                        plev_next = plev_reg | piu_pkg::level_bit(dev_level);
                    end
                    busy_next[dev_idx] = 1'b0;
                    fin_next[dev_idx]  = 1'b1;
                end
            end
            piu_pkg::OP_DEV_CLEAR:
            begin
                if (dev_ok)
                begin
                    plev_next          = plev_reg & ~piu_pkg::level_bit(dev_level);
                    busy_next[dev_idx] = 1'b0;
                    fin_next[dev_idx]  = 1'b0;
                    pend_next[dev_idx] = 1'b0;
                end
            end
            piu_pkg::OP_SKP_INTON:  skip_next = inton_reg;
            piu_pkg::OP_SKP_INTOFF: skip_next = !inton_reg;
            piu_pkg::OP_SKP_PWRF:   skip_next = 1'b0;
            piu_pkg::OP_SKP_NOPWRF: skip_next = 1'b1;
            piu_pkg::OP_INTEN:      enpend_next = 1'b1;
            piu_pkg::OP_INTDS:      inton_next = 1'b0;
            piu_pkg::OP_IORST:
            begin
                pend_next = '0;
                busy_next = '0;
                fin_next  = '0;
                plev_next = '0;
                mask_next = '0;
            end
            piu_pkg::OP_MSKO:       mask_next = wdata_reg;
            piu_pkg::OP_INTA:
            begin
                rdata_next = {{(piu_pkg::WORD_W-IDX_W){1'b0}}, best_dev_reg};
            end
            piu_pkg::OP_READS:      rdata_next = switches_reg;
            piu_pkg::OP_HALT:       halt_next = 1'b1;
            default:
            begin
                skip_next = 1'b0;
            end
        endcase
        done_next = dev_ok && fin_next[dev_idx];
    end

    // Commit state on execute; load configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inton_reg    <= 1'b0;
            enpend_reg   <= 1'b0;
            mask_reg     <= '0;
            plev_reg     <= '0;
            pend_reg     <= '0;
            busy_reg     <= '0;
            fin_reg      <= '0;
            lvalid_reg   <= '0;
            switches_reg <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                inton_reg  <= inton_next;
                enpend_reg <= enpend_next;
                mask_reg   <= mask_next;
                plev_reg   <= plev_next;
                pend_reg   <= pend_next;
                busy_reg   <= busy_next;
                fin_reg    <= fin_next;
                lvalid_reg <= lvalid_next;
            end
            if (cfg_we)
            begin
                switches_reg <= cfg_wdata;
            end
        end
    end

    // Result word: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            skip_reg  <= skip_next;
            rdata_reg <= rdata_next;
            take_reg  <= take_next;
            halt_reg  <= halt_next;
            done_reg  <= done_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_skip  = skip_reg;
    assign out_rdata = rdata_reg;
    assign out_take  = take_reg;
    assign out_halt  = halt_reg;
    assign out_done  = done_reg;

endmodule

@@ src/priority_interrupt_unit.sv @@
// Top level of the priority interrupt unit: stream ports and config port.
// Depends on piu_pkg, piu_ctrl and piu_datapath.
//
//  channel   direction  signals                     word
//  s_*       in         s_tvalid s_tready           operation on tuser, operands on tdata
//                       s_tdata s_tuser
//  m_*       out        m_tvalid m_tready m_tdata   skip, read data and status flags
//  cfg_*     in         cfg_valid cfg_ready         front panel switch word
//                       cfg_data
//
// One word is worked at a time. Acknowledge passes through fetch, scan, drain and
// execute, the scan reading the device level memory one read a cycle; every other
// operation goes from fetch straight to execute.
// Reset clears all interrupt state and device flags at once; no clearing pass.
// A waiting result does not block the next accept; a stall on m_tready holds
// the finished work in the execute step until the result register frees.
module priority_interrupt_unit
#(
    parameter int NUM_DEVICES = 63
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [5:0] device, [9:6] priority_level,
                                   // [25:10] write_data, [31:26] zero
    input  logic [3:0]  s_tuser,   // [3:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] skip, [16:1] read_data, [17] take_interrupt,
                                   // [18] halt, [19] device_done, [23:20] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    piu_pkg::cmd_t    cmd;
    piu_pkg::status_t status;

    logic        out_skip;
    logic [15:0] out_rdata;
    logic        out_take;
    logic        out_halt;
    logic        out_done;

    assign cfg_ready = 1'b1;

    piu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    piu_datapath #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_tuser),
        .in_device (s_tdata[5:0]),
        .in_level  (s_tdata[9:6]),
        .in_wdata  (s_tdata[25:10]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_wdata (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_skip  (out_skip),
        .out_rdata (out_rdata),
        .out_take  (out_take),
        .out_halt  (out_halt),
        .out_done  (out_done)
    );

    // Pack the result word
    assign m_tdata = {4'b0000, out_done, out_halt, out_take, out_rdata, out_skip};

endmodule
